/* rtl/ptpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpr_pkg
// Shared widths, codes and the outlet split for the phasor pulse router.
// ----------------------------------------------------------------------------
package ptpr_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ENTRY_WIDTH = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FRAMES_W    = $clog2(TABLE_DEPTH) + 1;
    localparam int PHASE_W     = 16;
    localparam int PROD_W      = PHASE_W + ADDR_W;
    // a wrapped sweep can cover close to twice the table
    localparam int ACC_W       = ENTRY_WIDTH + ADDR_W + 1;
    localparam int OUTLETS     = 5;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_PHASOR = 1'b1;

    // Greedy split over thresholds 15, 7, 3, 1; anything above 32 splits as 32.
    function automatic logic [OUTLETS-1:0] split_pulses(input logic signed [ACC_W-1:0] s);
        logic [5:0]         v;
        logic [OUTLETS-1:0] b;
        b = '0;
        if (s <= 0) begin
            v = 6'd0;
        end else if (s > 32) begin
            v = 6'd32;
        end else begin
            v = s[5:0];
        end
        if (v > 6'd15) begin
            b[4] = 1'b1;
            v    = v - 6'd16;
        end
        if (v > 6'd7) begin
            b[3] = 1'b1;
            v    = v - 6'd8;
        end
        if (v > 6'd3) begin
            b[2] = 1'b1;
            v    = v - 6'd4;
        end
        if (v > 6'd1) begin
            b[1] = 1'b1;
            v    = v - 6'd2;
        end
        if (v == 6'd1) begin
            b[0] = 1'b1;
        end
        return b;
    endfunction

endpackage

/* rtl/phasor_table_pulse_router_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phasor_table_pulse_router_unit
// Table of pulse codes swept by a phasor; the swept sum drives five outlets.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): i_operation selects a table write
// (i_table_address, i_table_value; no output word) or a phasor sample
// (i_phase; exactly one output word). Output channel (o_valid / i_stall)
// carries o_routed_pulses. Frame count is written over i_cfg_valid /
// o_cfg_ready; the user writes it only while the block is idle, and the block itself does not enforce this.
// A table write leaves the block idle. A phasor sample reads the swept
// entries from the table RAM, one entry a cycle, through S_SEG0 and S_SEG1,
// then passes S_FLUSH and S_DONE on its way to the output register.
// The next word is taken once the sum has been moved to the output register,
// even while that register still waits for the receiver.
// While the receiver stalls, the output word holds and a finished sum waits
// in the accumulator; the input stays stalled until it can be moved on.
// Reset (synchronous) clears the phase history to zero, sets the frame count
// to 1024 and empties the output; table contents are kept and are undefined
// until written.
// ----------------------------------------------------------------------------
module phasor_table_pulse_router_unit
    import ptpr_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [ADDR_W-1:0]             i_table_address,
    input  logic signed [ENTRY_WIDTH-1:0] i_table_value,
    input  logic [PHASE_W-1:0]            i_phase,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [OUTLETS-1:0]            o_routed_pulses,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [FRAMES_W-1:0]           i_cfg_frames_in_use
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG0,
        S_SEG1,
        S_FLUSH,
        S_DONE
    } t_state;

    logic signed [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic signed [ENTRY_WIDTH-1:0] r_rd_data;

    t_state                  r_state,      n_state;
    logic [FRAMES_W-1:0]     r_frames;
    logic [PHASE_W-1:0]      r_prev_phase, n_prev_phase;
    logic [ADDR_W-1:0]       r_prev_idx,   n_prev_idx;
    logic [ADDR_W-1:0]       r_ptr,        n_ptr;
    logic [ADDR_W-1:0]       r_end0,       n_end0;
    logic [ADDR_W-1:0]       r_end1,       n_end1;
    logic signed [ACC_W-1:0] r_acc,        n_acc;
    logic                    r_rd_vld,     n_rd_vld;
    logic                    r_out_vld,    n_out_vld;
    logic [OUTLETS-1:0]      r_out,        n_out;

    logic                    w_in_acc;
    logic                    w_wr_en;
    logic [FRAMES_W-1:0]     w_f;
    logic [ADDR_W-1:0]       w_fm1;
    logic [PROD_W-1:0]       w_prod;
    logic [ADDR_W-1:0]       w_idx;

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_vld;
    assign o_routed_pulses = r_out;
    assign o_cfg_ready     = 1'b1;

    assign w_in_acc = i_valid && !o_stall;
    assign w_wr_en  = w_in_acc && (i_operation == OP_WRITE);

    always_comb begin
        if (r_frames < FRAMES_W'(2)) begin
            w_f = FRAMES_W'(2);
        end else if (r_frames > FRAMES_W'(TABLE_DEPTH)) begin
            w_f = FRAMES_W'(TABLE_DEPTH);
        end else begin
            w_f = r_frames;
        end
    end

    assign w_fm1  = ADDR_W'(w_f - FRAMES_W'(1));
    assign w_prod = PROD_W'(i_phase) * PROD_W'(w_fm1);
    assign w_idx  = w_prod[PROD_W-1:PHASE_W];

    // table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[i_table_address] <= i_table_value;
        end
        r_rd_data <= mem[r_ptr];
    end

    always_comb begin
        n_state      = r_state;
        n_prev_phase = r_prev_phase;
        n_prev_idx   = r_prev_idx;
        n_ptr        = r_ptr;
        n_end0       = r_end0;
        n_end1       = r_end1;
        n_rd_vld     = 1'b0;
        n_acc        = r_rd_vld ? r_acc + ACC_W'(r_rd_data) : r_acc;
        n_out_vld    = r_out_vld && i_stall;
        n_out        = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_operation == OP_PHASOR)) begin
                    n_ptr        = r_prev_idx;
                    n_acc        = '0;
                    n_prev_phase = i_phase;
                    n_prev_idx   = w_idx;
                    if (i_phase > r_prev_phase) begin
                        n_end0 = w_idx;
                        n_end1 = '0;
                    end else if (i_phase < r_prev_phase) begin
                        n_end0 = w_fm1;
                        n_end1 = w_idx;
                    end else begin
                        n_end0 = '0;
                        n_end1 = '0;
                    end
                    n_state = S_SEG0;
                end
            end
            S_SEG0: begin
                if (r_ptr < r_end0) begin
                    n_rd_vld = 1'b1;
                    n_ptr    = r_ptr + ADDR_W'(1);
                end else begin
                    n_ptr   = '0;
                    n_state = S_SEG1;
                end
            end
            S_SEG1: begin
                if (r_ptr < r_end1) begin
                    n_rd_vld = 1'b1;
                    n_ptr    = r_ptr + ADDR_W'(1);
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld = 1'b1;
                    n_out     = split_pulses(r_acc);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_frames     <= FRAMES_W'(TABLE_DEPTH);
            r_prev_phase <= '0;
            r_prev_idx   <= '0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_phase <= n_prev_phase;
            r_prev_idx   <= n_prev_idx;
            r_rd_vld     <= n_rd_vld;
            r_out_vld    <= n_out_vld;
            if (i_cfg_valid) begin
                r_frames <= i_cfg_frames_in_use;
            end
        end
        r_ptr  <= n_ptr;
        r_end0 <= n_end0;
        r_end1 <= n_end1;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

endmodule

/* rtl/ptpr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpr_checker
// Port-level checks for the phasor pulse router, bound to the top level.
// ----------------------------------------------------------------------------
module ptpr_checker
    import ptpr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_operation,
    input logic               o_valid,
    input logic               i_stall,
    input logic [OUTLETS-1:0] o_routed_pulses
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not cleared by reset");

    a_write_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_operation == OP_WRITE) |=> !o_stall)
        else $error("table write left the input stalled");

    a_phasor_no_instant_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_operation == OP_PHASOR) |=> o_stall && !$rose(o_valid))
        else $error("phasor word handled too early");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_routed_pulses))
        else $error("stalled output word changed");

endmodule

bind phasor_table_pulse_router_unit ptpr_checker u_ptpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_operation     (i_operation),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_routed_pulses (o_routed_pulses)
);

/* tb/sv/phasor_table_pulse_router_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phasor_table_pulse_router_unit_tb
// Self-checking bench for the phasor pulse router. A queue-fed driver offers
// table writes and phasor samples, a clocked monitor predicts the outlet word
// of every accepted sample and checks each output word in order. The run
// steps through several frame counts, clamped ones included, with random
// idling on both sides, one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module phasor_table_pulse_router_unit_tb;
    import ptpr_pkg::*;

    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 30;

    typedef struct {
        logic                          op;
        logic [ADDR_W-1:0]             addr;
        logic signed [ENTRY_WIDTH-1:0] value;
        logic [PHASE_W-1:0]            phase;
        bit                            drain_first;
    } router_word_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_operation = OP_WRITE;
    logic [ADDR_W-1:0]             i_table_address = '0;
    logic signed [ENTRY_WIDTH-1:0] i_table_value = '0;
    logic [PHASE_W-1:0]            i_phase = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [OUTLETS-1:0]            o_routed_pulses;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [FRAMES_W-1:0]           i_cfg_frames_in_use = '0;

    phasor_table_pulse_router_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_operation         (i_operation),
        .i_table_address     (i_table_address),
        .i_table_value       (i_table_value),
        .i_phase             (i_phase),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_routed_pulses     (o_routed_pulses),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_frames_in_use (i_cfg_frames_in_use)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // stimulus queue and planning shadow
    router_word_t pending_words[$];
    bit           written [TABLE_DEPTH];
    logic [PHASE_W-1:0] plan_phase = '0;
    int           plan_index = 0;
    int           plan_frames = TABLE_DEPTH;

    // predictor state
    logic signed [ENTRY_WIDTH-1:0] codes [TABLE_DEPTH];
    logic [PHASE_W-1:0]            last_phase = '0;
    int                            last_index = 0;
    int                            frame_reg = TABLE_DEPTH;
    logic [OUTLETS-1:0]            outlets_due[$];

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit hold_request = 1'b0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int tx_wait = 0;
    int rx_wait = 0;
    int long_hold_left = 0;

    int fault_count = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_phasors = 0;
    int n_settings = 0;
    int frame_plan [9];

    function automatic int usable_frames(input int f);
        if (f < 2) return 2;
        if (f > TABLE_DEPTH) return TABLE_DEPTH;
        return f;
    endfunction

    function automatic int sweep_index(input logic [PHASE_W-1:0] ph, input int f);
        return (int'(ph) * (f - 1)) >>> 16;
    endfunction

    function automatic longint swept_sum(input int from, input int to);
        longint acc;
        acc = 0;
        for (int k = from; k < to && k < TABLE_DEPTH; k++) acc += codes[k];
        return acc;
    endfunction

    function automatic logic [OUTLETS-1:0] outlet_bits(input longint s);
        logic [OUTLETS-1:0] b;
        b = '0;
        if (s > 15) begin
            s -= 16;
            b[4] = 1'b1;
        end
        if (s > 7) begin
            s -= 8;
            b[3] = 1'b1;
        end
        if (s > 3) begin
            s -= 4;
            b[2] = 1'b1;
        end
        if (s > 1) begin
            s -= 2;
            b[1] = 1'b1;
        end
        if (s == 1) b[0] = 1'b1;
        return b;
    endfunction

    function automatic int random_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return int'($urandom_range(0, 16)) - 4;
        if (pick < 85) return int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 3))
            0: return 32767;
            1: return -32768;
            2: return -1;
            default: return 1;
        endcase
    endfunction

    task automatic report_fault(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic compute_outlets(input logic op, input logic [ADDR_W-1:0] addr,
                                   input logic signed [ENTRY_WIDTH-1:0] value,
                                   input logic [PHASE_W-1:0] ph);
        int     f;
        int     idx;
        longint s;
        if (op == OP_WRITE) begin
            codes[addr] = value;
        end else begin
            f   = usable_frames(frame_reg);
            idx = sweep_index(ph, f);
            if (ph > last_phase) begin
                s = swept_sum(last_index, idx);
            end else if (ph < last_phase) begin
                s = swept_sum(last_index, f - 1) + swept_sum(0, idx);
            end else begin
                s = 0;
            end
            last_phase = ph;
            last_index = idx;
            outlets_due.push_back(outlet_bits(s));
        end
    endtask

    task automatic push_write(input int addr, input int code);
        router_word_t w;
        w.op          = OP_WRITE;
        w.addr        = ADDR_W'(addr);
        w.value       = ENTRY_WIDTH'(code);
        w.phase       = PHASE_W'($urandom_range(0, 65535));
        w.drain_first = 1'b0;
        pending_words.push_back(w);
        written[addr] = 1'b1;
        n_writes++;
    endtask

    // entries a sample will sweep get a value first, so no unwritten entry is read
    task automatic fill_codes(input int from, input int to);
        for (int k = from; k < to && k < TABLE_DEPTH; k++) begin
            if (!written[k]) push_write(k, random_code());
        end
    endtask

    task automatic plan_phasor(input logic [PHASE_W-1:0] ph, input bit drain);
        router_word_t w;
        int           f;
        int           idx;
        f   = usable_frames(plan_frames);
        idx = sweep_index(ph, f);
        if (ph > plan_phase) begin
            fill_codes(plan_index, idx);
        end else if (ph < plan_phase) begin
            fill_codes(plan_index, f - 1);
            fill_codes(0, idx);
        end
        plan_phase    = ph;
        plan_index    = idx;
        w.op          = OP_PHASOR;
        w.addr        = ADDR_W'($urandom_range(0, TABLE_DEPTH - 1));
        w.value       = ENTRY_WIDTH'($urandom_range(0, 65535));
        w.phase       = ph;
        w.drain_first = drain;
        pending_words.push_back(w);
        n_phasors++;
    endtask

    // table writes and a running phasor with mostly small steps, plus jumps and repeats
    task automatic fill_random(input int count);
        int f;
        int max_step;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                push_write($urandom_range(0, TABLE_DEPTH - 1), random_code());
            end else if (pick < 88) begin
                f        = usable_frames(plan_frames);
                max_step = (65536 * 8) / (f - 1);
                if (max_step > 65535) max_step = 65535;
                plan_phasor(PHASE_W'(int'(plan_phase) + int'($urandom_range(0, max_step))), 1'b0);
            end else if (pick < 94) begin
                plan_phasor(PHASE_W'($urandom_range(0, 65535)), 1'b0);
            end else begin
                plan_phasor(plan_phase, 1'b0);
            end
        end
    endtask

    task automatic wait_idle;
        do @(posedge i_clk);
        while (pending_words.size() != 0 || i_valid || outlets_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frames(input int frames);
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_frames_in_use <= FRAMES_W'(frames);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        plan_frames = frames;
        n_settings++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        router_word_t w;
        logic         next_valid;
        next_valid = i_valid;
        if (in_taken) begin
            in_taken   = 1'b0;
            next_valid = 1'b0;
            tx_wait    = tx_burst ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
        end
        if (!next_valid) begin
            if (tx_wait > 0) begin
                tx_wait--;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain_first && outlets_due.size() != 0)) begin
                w               = pending_words.pop_front();
                i_operation     <= w.op;
                i_table_address <= w.addr;
                i_table_value   <= w.value;
                i_phase         <= w.phase;
                next_valid      = 1'b1;
            end
        end
        i_valid <= next_valid;
    end

    // receiver stall
    always @(negedge i_clk) begin
        if (long_hold_left > 0) begin
            long_hold_left--;
            i_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request   = 1'b0;
            long_hold_left = LONG_HOLD;
            i_stall        <= 1'b1;
        end else begin
            if (out_taken) begin
                out_taken = 1'b0;
                rx_wait   = rx_burst ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor: check output words, then predict from accepted input words
    always @(posedge i_clk) begin
        logic [OUTLETS-1:0] due;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                out_taken = 1'b1;
                if (outlets_due.size() == 0) begin
                    report_fault($sformatf("unexpected outlet word %b", o_routed_pulses));
                end else begin
                    due = outlets_due.pop_front();
                    n_checked++;
                    if (o_routed_pulses !== due)
                        report_fault($sformatf("routed_pulses expected %b got %b",
                                               due, o_routed_pulses));
                end
            end
            if (i_cfg_valid && o_cfg_ready) frame_reg = int'(i_cfg_frames_in_use);
            if (i_valid && !o_stall) begin
                in_taken = 1'b1;
                compute_outlets(i_operation, i_table_address, i_table_value, i_phase);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        frame_plan = '{1024, 2, 2047, 0, 200, 1, 1025, 37, 1024};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: four frames, index range 0..2
        write_frames(4);
        push_write(0, 32767);
        push_write(1, -32768);
        push_write(2, 5);
        push_write(TABLE_DEPTH - 1, -1);
        push_write(512, 0);
        plan_phasor(16'd0, 1'b0);
        plan_phasor(16'hFFFF, 1'b0);
        plan_phasor(16'hFFFF, 1'b0);
        plan_phasor(16'd0, 1'b0);
        push_write(0, 16);
        push_write(1, 15);
        push_write(2, -2);
        plan_phasor(16'd21846, 1'b0);
        plan_phasor(16'hFFFF, 1'b0);
        plan_phasor(16'd100, 1'b0);
        push_write(2, 40);
        plan_phasor(16'hFFFF, 1'b0);
        plan_phasor(16'd0, 1'b0);

        foreach (frame_plan[p]) begin
            wait_idle();
            write_frames(frame_plan[p]);
            if (p == 5) begin
                fill_random(PHASE_ITEMS / 2);
                plan_phasor(PHASE_W'(int'(plan_phase) + 1), 1'b1);
                fill_random(PHASE_ITEMS / 2);
            end else begin
                fill_random(PHASE_ITEMS);
            end
            if (p == 2) begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d table writes and %0d phasor samples over %0d frame settings.",
                 n_writes, n_phasors, n_settings);
        $display("%0d outlet words checked, %0d mismatches.", n_checked, fault_count);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* phasor_table_pulse_router_unit.f */
rtl/ptpr_pkg.sv
rtl/phasor_table_pulse_router_unit.sv
rtl/ptpr_checker.sv
tb/sv/phasor_table_pulse_router_unit_tb.sv
